FILE: rtl/tick_task_scheduler_top_assert.svh
// ----------------------------------------------------------------------------
// Tick task scheduler assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TICK_TASK_SCHEDULER_TOP_ASSERT_SVH
`define TICK_TASK_SCHEDULER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define TTS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tick_task_scheduler assertion failed");
`define TTS_ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("tick_task_scheduler assertion failed");
`else
`define TTS_ASSERT(lbl, clk, rst, prop)
`define TTS_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif

`endif

FILE: rtl/tts_pkg.sv
// ----------------------------------------------------------------------------
// Tick task scheduler package
// Field widths, stream layouts, slot entry layout and control codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

  localparam int SLOTS_DEF   = 8;
  localparam int MAX_RESULTS = 8;
  localparam int HIT_W       = $clog2(MAX_RESULTS + 1);

  localparam int CMD_W   = 2;
  localparam int SLOT_W  = 3;
  localparam int ID_W    = 7;
  localparam int DELAY_W = 15;
  localparam int PEND_W  = 7;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_PAD_W   = OUT_TDATA_W - ID_W - SLOT_W;

  localparam logic [PEND_W-1:0] PEND_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD      = 2'd0,
    CMD_TICK     = 2'd1,
    CMD_DISPATCH = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic                armed;
    logic [PEND_W-1:0]   pending;
    logic [DELAY_W-1:0]  period;
    logic [DELAY_W-1:0]  delay;
    logic [ID_W-1:0]     id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

FILE: rtl/tick_task_scheduler_top.sv
// Add, tick and dispatch each pass through the scan and flush states before ready
// returns; dispatch can also be held there by output-side back-pressure.
// Unless an output stall holds it, one slot entry is read and written back per
// cycle; the slot RAM port sets this. One command in flight at a time; a result
// may still wait at the output. Reset clears control state and per-slot valid
// flags; unwritten slots read as zero, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// Tick task scheduler top level
// Time-triggered task table: add writes one slot; tick and dispatch walk a slot RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module tick_task_scheduler_top #(
  parameter int SLOTS = tts_pkg::SLOTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // command, slot, task_id, start_delay, period (lowest first), zero pad
  input  wire logic [tts_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // run_task_id, run_slot (lowest first), zero pad
  output logic [tts_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tlast
);

  import tts_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  // input beat fields
  logic [CMD_W-1:0]   in_cmd;
  logic [SLOT_W-1:0]  in_slot;
  logic [ID_W-1:0]    in_id;
  logic [DELAY_W-1:0] in_delay;
  logic [DELAY_W-1:0] in_period;

  assign in_cmd    = s_axis_tdata[1:0];
  assign in_slot   = s_axis_tdata[4:2];
  assign in_id     = s_axis_tdata[11:5];
  assign in_delay  = s_axis_tdata[26:12];
  assign in_period = s_axis_tdata[41:27];

  state_t state, state_next;

  cmd_t               cmd_q;
  logic [ID_W-1:0]    add_id;
  logic [DELAY_W-1:0] add_delay;
  logic [DELAY_W-1:0] add_period;

  logic [CW-1:0]      rd_cnt;
  logic               ex_valid;
  logic [AW-1:0]      ex_idx;
  logic [SLOTS-1:0]   vld;
  logic [HIT_W-1:0]   hit_cnt;

  logic               hold_valid;
  logic [ID_W-1:0]    hold_id;
  logic [SLOT_W-1:0]  hold_slot;

  logic               out_valid;
  logic [ID_W-1:0]    out_id;
  logic [SLOT_W-1:0]  out_slot;
  logic               out_last;

  logic               accept;
  logic               start_walk;
  logic               start_add;
  logic               more;
  logic               out_free;
  logic               hit;
  logic               stall;
  logic               out_load;

  logic               ram_we;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             cur;
  entry_t             upd;

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign start_walk = accept && (in_cmd == CMD_TICK || in_cmd == CMD_DISPATCH);
  assign start_add  = accept && (in_cmd == CMD_ADD) && (int'(in_slot) < SLOTS);
  assign more       = (rd_cnt != CW'(SLOTS));
  assign out_free   = !out_valid || m_axis_tready;

  tts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ex_idx),
    .wdata (upd),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // slot update
  always_comb begin
    cur = vld[ex_idx] ? entry_t'(ram_rdata) : '0;
    upd = cur;
    hit = 1'b0;
    unique case (cmd_q)
      CMD_ADD: begin
        upd.id     = add_id;
        upd.delay  = add_delay;
        upd.period = add_period;
        upd.armed  = 1'b1;
      end
      CMD_TICK: begin
        if (cur.id != '0 && cur.armed) begin
          if (cur.delay == '0) begin
            if (cur.pending != PEND_MAX) begin
              upd.pending = cur.pending + PEND_W'(1);
            end
            if (cur.period != '0) begin
              upd.delay = cur.period;
            end else begin
              upd.armed = 1'b0;
            end
          end else begin
            upd.delay = cur.delay - DELAY_W'(1);
          end
        end
      end
      CMD_DISPATCH: begin
        hit = ex_valid && (cur.id != '0) && (cur.pending != '0) &&
              (hit_cnt < HIT_W'(MAX_RESULTS));
        if (hit) begin
          upd.pending = cur.pending - PEND_W'(1);
        end
      end
      default: begin
        upd = cur;
      end
    endcase
  end

  assign stall = (state == ST_SCAN) && hit && hold_valid && !out_free;

  // output register loads from the hold stage
  assign out_load = ((state == ST_SCAN) && !stall && hit && hold_valid) ||
                    ((state == ST_FLUSH) && hold_valid && out_free);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start_walk || start_add) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!stall && !more) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!hold_valid || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs of the controller
  always_comb begin
    s_axis_tready = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    ram_we        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        ram_re        = start_walk || start_add;
        ram_raddr     = start_add ? AW'(in_slot) : '0;
      end
      ST_SCAN: begin
        ram_we    = ex_valid && !stall;
        ram_re    = !stall && more;
        ram_raddr = rd_cnt[AW-1:0];
      end
      ST_FLUSH: begin
        ram_re = 1'b0;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rd_cnt     <= '0;
      ex_valid   <= 1'b0;
      vld        <= '0;
      hit_cnt    <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (start_walk || start_add) begin
            ex_valid <= 1'b1;
            rd_cnt   <= start_add ? CW'(SLOTS) : CW'(1);
            hit_cnt  <= '0;
          end
        end
        ST_SCAN: begin
          if (!stall) begin
            if (ram_we) begin
              vld[ex_idx] <= 1'b1;
            end
            if (hit) begin
              hold_valid <= 1'b1;
              hit_cnt    <= hit_cnt + HIT_W'(1);
            end
            if (more) begin
              rd_cnt   <= rd_cnt + CW'(1);
              ex_valid <= 1'b1;
            end else begin
              ex_valid <= 1'b0;
            end
          end
        end
        ST_FLUSH: begin
          if (hold_valid && out_free) begin
            hold_valid <= 1'b0;
          end
        end
        default: begin
          ex_valid <= 1'b0;
        end
      endcase
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && (start_walk || start_add)) begin
      cmd_q      <= cmd_t'(in_cmd);
      add_id     <= in_id;
      add_delay  <= in_delay;
      add_period <= in_period;
      ex_idx     <= ram_raddr;
    end
    if (state == ST_SCAN && !stall) begin
      if (more) begin
        ex_idx <= rd_cnt[AW-1:0];
      end
      if (hit) begin
        hold_id   <= cur.id;
        hold_slot <= SLOT_W'(ex_idx);
        if (hold_valid) begin
          out_id   <= hold_id;
          out_slot <= hold_slot;
          out_last <= 1'b0;
        end
      end
    end
    if (state == ST_FLUSH && hold_valid && out_free) begin
      out_id   <= hold_id;
      out_slot <= hold_slot;
      out_last <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_slot, out_id};
  assign m_axis_tlast  = out_last;

`include "tick_task_scheduler_top_assert.svh"

  `TTS_ASSERT(a_hold_only_dispatch, clk, rst, hold_valid |-> (cmd_q == CMD_DISPATCH))
  `TTS_ASSERT(a_hit_cap, clk, rst, hit_cnt <= HIT_W'(MAX_RESULTS))
  `TTS_ASSERT(a_idle_drained, clk, rst, (state == ST_IDLE) |-> (!hold_valid && !ex_valid))
  `TTS_ASSERT_NEXT(a_stall_keeps_out, clk, rst, stall, out_valid && hold_valid)

endmodule

`default_nettype wire

FILE: rtl/tts_ram.sv
// ----------------------------------------------------------------------------
// Tick task scheduler RAM
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tick task scheduler testbench
// Sends add, tick, dispatch and unknown commands with random gaps, tracks the
// task table alongside the block and checks every dispatched run beat.
// ----------------------------------------------------------------------------

module testbench;
  import tts_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_LEN    = 500;
  localparam int HOLD_AT     = 30;
  localparam int RANDOM_CMDS = 180;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [SLOT_W-1:0]  slot;
    logic [ID_W-1:0]    id;
    logic [DELAY_W-1:0] delay;
    logic [DELAY_W-1:0] period;
  } sched_cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } run_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tlast;

  // task table as the block should hold it
  logic [ID_W-1:0]    tbl_id     [SLOTS_DEF];
  logic [DELAY_W-1:0] tbl_delay  [SLOTS_DEF];
  logic [DELAY_W-1:0] tbl_period [SLOTS_DEF];
  logic [PEND_W-1:0]  tbl_pend   [SLOTS_DEF];
  logic               tbl_armed  [SLOTS_DEF];

  sched_cmd_t cmd_backlog [$];
  run_t       due_runs [$];
  sched_cmd_t cur_cmd;

  int total_items = 0;
  int accepted_items = 0;
  int results_seen = 0;
  int error_count = 0;
  int in_gap = 0;
  int out_gap = 0;
  int hold_left = 0;
  int quiet = 0;
  bit hold_done = 1'b0;
  bit in_beat_done = 1'b0;

  tick_task_scheduler_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    for (int s = 0; s < SLOTS_DEF; s++) begin
      tbl_id[s] = '0;
      tbl_delay[s] = '0;
      tbl_period[s] = '0;
      tbl_pend[s] = '0;
      tbl_armed[s] = 1'b0;
    end
  end

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch on run beat %0d: %s got %0d expected %0d",
             results_seen, what, got, want);
    error_count++;
  endtask

  // update the table for one accepted command and queue the runs it yields
  task automatic advance_table(sched_cmd_t c);
    run_t batch [MAX_RESULTS];
    int n;
    n = 0;
    case (c.command)
      CMD_ADD: begin
        tbl_id[c.slot] = c.id;
        tbl_delay[c.slot] = c.delay;
        tbl_period[c.slot] = c.period;
        tbl_armed[c.slot] = 1'b1;
      end
      CMD_TICK: begin
        for (int s = 0; s < SLOTS_DEF; s++) begin
          if (tbl_id[s] != '0 && tbl_armed[s]) begin
            if (tbl_delay[s] == '0) begin
              if (tbl_pend[s] != PEND_MAX) tbl_pend[s] = tbl_pend[s] + 1'b1;
              if (tbl_period[s] != '0) tbl_delay[s] = tbl_period[s];
              else tbl_armed[s] = 1'b0;
            end else begin
              tbl_delay[s] = tbl_delay[s] - 1'b1;
            end
          end
        end
      end
      CMD_DISPATCH: begin
        for (int s = 0; s < SLOTS_DEF && n < MAX_RESULTS; s++) begin
          if (tbl_id[s] != '0 && tbl_pend[s] != '0) begin
            batch[n].id = tbl_id[s];
            batch[n].slot = s[SLOT_W-1:0];
            batch[n].last = 1'b0;
            tbl_pend[s] = tbl_pend[s] - 1'b1;
            n++;
          end
        end
        if (n > 0) batch[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) due_runs.push_back(batch[k]);
      end
      default: ;
    endcase
  endtask

  function automatic sched_cmd_t make_cmd(logic [CMD_W-1:0] command, int slot, int id,
                                          int delay, int period);
    sched_cmd_t c;
    c.command = command;
    c.slot = slot[SLOT_W-1:0];
    c.id = id[ID_W-1:0];
    c.delay = delay[DELAY_W-1:0];
    c.period = period[DELAY_W-1:0];
    return c;
  endfunction

  function automatic sched_cmd_t random_cmd();
    sched_cmd_t c;
    int pick;
    pick = $urandom_range(0, 99);
    c.slot = SLOT_W'($urandom);
    c.id = ID_W'($urandom);
    c.delay = DELAY_W'($urandom);
    c.period = DELAY_W'($urandom);
    if (pick < 25) begin
      c.command = CMD_ADD;
      c.id = ($urandom_range(0, 9) == 0) ? '0 : ID_W'($urandom_range(1, 127));
      if ($urandom_range(0, 7) != 0) c.delay = DELAY_W'($urandom_range(0, 6));
      if ($urandom_range(0, 7) != 0) c.period = DELAY_W'($urandom_range(0, 5));
    end else if (pick < 70) begin
      c.command = CMD_TICK;
    end else if (pick < 95) begin
      c.command = CMD_DISPATCH;
    end else begin
      c.command = CMD_UNKNOWN;
    end
    return c;
  endfunction

  function automatic int draw_gap(int count, int span);
    return ((count / span) % 3 == 1) ? 0 : $urandom_range(0, 9);
  endfunction

  // command driver
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!(s_axis_tvalid && !in_beat_done)) begin
      in_beat_done = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        cur_cmd = cmd_backlog.pop_front();
        s_axis_tdata <= {6'd0, cur_cmd.period, cur_cmd.delay, cur_cmd.id, cur_cmd.slot,
                         cur_cmd.command};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      advance_table(cur_cmd);
      accepted_items++;
      in_beat_done = 1'b1;
      in_gap = draw_gap(accepted_items, 50);
    end
  end

  // run receiver, with one long hold-off to back the block up
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // run monitor
  always @(posedge clk) begin
    run_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (due_runs.size() == 0) begin
        report_mismatch("unexpected run, task id", 32'(m_axis_tdata[ID_W-1:0]), 0);
      end else begin
        want = due_runs.pop_front();
        if (m_axis_tdata[ID_W-1:0] != want.id)
          report_mismatch("task id", 32'(m_axis_tdata[ID_W-1:0]), 32'(want.id));
        if (m_axis_tdata[ID_W+SLOT_W-1:ID_W] != want.slot)
          report_mismatch("slot", 32'(m_axis_tdata[ID_W+SLOT_W-1:ID_W]), 32'(want.slot));
        if (m_axis_tlast != want.last)
          report_mismatch("tlast", 32'(m_axis_tlast), 32'(want.last));
        if (m_axis_tdata[OUT_TDATA_W-1:ID_W+SLOT_W] != '0)
          report_mismatch("pad", 32'(m_axis_tdata[OUT_TDATA_W-1:ID_W+SLOT_W]), 0);
      end
      results_seen++;
      out_gap = draw_gap(results_seen, 60);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet == QUIET_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  initial begin
    // directed: empty table, unknown code, extremes, one-shot, empty slot
    cmd_backlog.push_back(make_cmd(CMD_DISPATCH, 0, 0, 0, 0));
    cmd_backlog.push_back(make_cmd(CMD_UNKNOWN, 7, 127, 32767, 32767));
    cmd_backlog.push_back(make_cmd(CMD_ADD, 0, 127, 0, 0));
    cmd_backlog.push_back(make_cmd(CMD_ADD, 7, 1, 32767, 32767));
    cmd_backlog.push_back(make_cmd(CMD_ADD, 1, 42, 1, 1));
    cmd_backlog.push_back(make_cmd(CMD_ADD, 2, 5, 0, 2));
    repeat (3) cmd_backlog.push_back(make_cmd(CMD_TICK, 0, 0, 0, 0));
    cmd_backlog.push_back(make_cmd(CMD_DISPATCH, 0, 0, 0, 0));
    for (int s = 3; s <= 6; s++) cmd_backlog.push_back(make_cmd(CMD_ADD, s, 10 + s, 0, 1));
    cmd_backlog.push_back(make_cmd(CMD_ADD, 0, 127, 0, 0));
    cmd_backlog.push_back(make_cmd(CMD_ADD, 7, 1, 0, 32767));
    cmd_backlog.push_back(make_cmd(CMD_TICK, 0, 0, 0, 0));
    cmd_backlog.push_back(make_cmd(CMD_DISPATCH, 0, 0, 0, 0));
    repeat (2) cmd_backlog.push_back(make_cmd(CMD_TICK, 0, 0, 0, 0));
    cmd_backlog.push_back(make_cmd(CMD_ADD, 4, 0, 3, 3));
    cmd_backlog.push_back(make_cmd(CMD_DISPATCH, 0, 0, 0, 0));
    cmd_backlog.push_back(make_cmd(CMD_ADD, 4, 99, 32767, 0));
    cmd_backlog.push_back(make_cmd(CMD_DISPATCH, 0, 0, 0, 0));

    // pending count saturation on one slot; the count left over keeps the
    // random phase busy
    cmd_backlog.push_back(make_cmd(CMD_ADD, 0, 100, 0, 1));
    for (int s = 1; s < SLOTS_DEF; s++) cmd_backlog.push_back(make_cmd(CMD_ADD, s, 0, 0, 0));
    repeat (260) cmd_backlog.push_back(make_cmd(CMD_TICK, 0, 0, 0, 0));
    repeat (6) cmd_backlog.push_back(make_cmd(CMD_DISPATCH, 0, 0, 0, 0));

    repeat (RANDOM_CMDS) cmd_backlog.push_back(random_cmd());
    total_items = cmd_backlog.size();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (accepted_items != total_items) @(posedge clk);
    while (due_runs.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
